[src/searchable_fifo_queue_assert.svh]
// Assertion macros for the searchable FIFO queue.
`ifndef SEARCHABLE_FIFO_QUEUE_ASSERT_SVH
`define SEARCHABLE_FIFO_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFQ_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SFQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/sfq_pkg.sv]
// Shared types and codes for the searchable FIFO queue.
package sfq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  item_type;
    logic [31:0] item_value;
  } sfq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic       queue_empty;
  } sfq_out_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } sfq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } sfq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;
  } sfq_stat_t;

endpackage

[src/sfq_ctrl.sv]
// Command sequencer: capture a command, then execute it once the result register frees.
module sfq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfq_pkg::sfq_stat_t stat,
  output sfq_pkg::sfq_cmd_t  cmd
);

  sfq_pkg::sfq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sfq_pkg::S_EXEC;
      end
      sfq_pkg::S_EXEC: begin
        if (!stat.out_stall) state_nxt = sfq_pkg::S_IDLE;
      end
      default: state_nxt = sfq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      sfq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      sfq_pkg::S_EXEC: begin
        cmd.execute = !stat.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/sfq_dp.sv]
// Queue storage, per-entry match compare, close-up shift and result register.
module sfq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfq_pkg::sfq_in_t   in_data,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  sfq_pkg::sfq_cmd_t  cmd,
  output sfq_pkg::sfq_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output sfq_pkg::sfq_out_t  out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [31:0]            entries_r [QUEUE_DEPTH];
  logic [CW-1:0]          count_r, count_nxt;
  logic [3:0]             elem_type_r;
  logic [1:0]             op_r;
  logic                   type_ok_r;
  logic [31:0]            value_r;
  logic [QUEUE_DEPTH-1:0] hit_r, hit_nxt;
  logic                   out_valid_r;
  sfq_pkg::sfq_out_t      out_r, out_nxt;

  logic [QUEUE_DEPTH-1:0] first_hit, shift_en;
  logic                   any_hit, do_insert, do_remove;
  logic [1:0]             status;
  logic [CW+4:0]          count_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r <= 4'd0;
    end else if (cfg_we) begin
      elem_type_r <= cfg_wdata;
    end
  end

  // Parallel compare against every held entry at capture.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_nxt[i] = (entries_r[i] == in_data.item_value) && (CW'(i) < count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_data.operation;
      type_ok_r <= (in_data.item_type == elem_type_r);
      value_r   <= in_data.item_value;
      hit_r     <= hit_nxt;
    end
  end

  // Isolate lowest hit; every slot from it upward but the top one takes its upper neighbor.
  assign any_hit   = |hit_r;
  assign first_hit = hit_r & (~hit_r + QUEUE_DEPTH'(1));
  assign shift_en  = ~(first_hit - QUEUE_DEPTH'(1));

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    count_nxt = count_r;
    if (op_r == sfq_pkg::OP_INSERT) begin
      if (!type_ok_r)            status = sfq_pkg::ST_MISMATCH;
      else if (count_r == FULL_CNT) status = sfq_pkg::ST_FULL;
      else begin
        status    = sfq_pkg::ST_OK;
        do_insert = 1'b1;
        count_nxt = count_r + CW'(1);
      end
    end else if (op_r == sfq_pkg::OP_REMOVE) begin
      if (count_r == '0)         status = sfq_pkg::ST_NOTFOUND;
      else if (!type_ok_r)       status = sfq_pkg::ST_MISMATCH;
      else if (!any_hit)         status = sfq_pkg::ST_NOTFOUND;
      else begin
        status    = sfq_pkg::ST_OK;
        do_remove = 1'b1;
        count_nxt = count_r - CW'(1);
      end
    end else begin
      // search, and the unused code behaves the same
      if (!type_ok_r)            status = sfq_pkg::ST_MISMATCH;
      else if (any_hit)          status = sfq_pkg::ST_OK;
      else                       status = sfq_pkg::ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.execute && do_insert && (count_r == CW'(i))) begin
        entries_r[i] <= value_r;
      end else if (cmd.execute && do_remove && shift_en[i] && (i < QUEUE_DEPTH - 1)) begin
        entries_r[i] <= entries_r[(i + 1) % QUEUE_DEPTH];
      end
    end
  end

  assign count_ext = (CW+5)'(count_nxt);

  always_comb begin
    out_nxt.status      = status;
    out_nxt.entry_count = count_ext[4:0];
    out_nxt.queue_empty = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) out_r <= out_nxt;
  end

  assign stat.out_stall = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

[src/searchable_fifo_queue.sv]
// Top level of the searchable FIFO queue.
// Usage:
//   Commands arrive on in_valid/in_ready with in_data (operation, item_type,
//   item_value); one result per command leaves on out_valid/out_ready with
//   out_data (status, entry_count, queue_empty). cfg_we/cfg_wdata set the
//   element type tag; write it only while the block is idle.
//   Steps: the accepting edge registers a compare of the value against every
//   held entry; the execute step, once the result register is free, applies
//   the insert or the close-up shift and loads the result register.
//   A new command is not taken until the previous one has executed, as the
//   compare-then-update sequence runs on the single entry array.
//   A new command can be taken while the previous result waits in the
//   output register; if the receiver stalls, the next command waits in its
//   execute step until the result register drains.
//   Reset clears the count, element type and valid flags; entry storage is
//   not cleared and needs no clearing pass.
module searchable_fifo_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfq_pkg::sfq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfq_pkg::sfq_out_t out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);

  localparam logic [4:0] DEPTH_LOW = 5'(QUEUE_DEPTH);

  sfq_pkg::sfq_cmd_t  cmd;
  sfq_pkg::sfq_stat_t stat;

  sfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`include "searchable_fifo_queue_assert.svh"

  `SFQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready high during execute")
  `SFQ_ASSERT_NOW(a_empty_count, out_valid && out_data.queue_empty, out_data.entry_count == 5'd0, "empty flag with nonzero count")
  `SFQ_ASSERT_NOW(a_full_count, out_valid && (out_data.status == sfq_pkg::ST_FULL), out_data.entry_count == DEPTH_LOW, "full status below capacity")
  `SFQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready && !(out_valid && !out_ready), ##1 out_valid, "result missing after execute")

endmodule
